FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/lha_pkg.sv
`default_nettype none
package lha_pkg;

  localparam int LANES_DEF   = 4;
  localparam int NUM_ID_REGS = 4;
  localparam int ID_W        = 16;
  localparam int TYPE_W      = 8;
  localparam int COUNT_W     = 16;
  localparam int TIME_W      = 32;
  localparam int GAP_W       = 31;
  localparam int CFG_W       = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int OP_W        = 2;

  localparam logic [COUNT_W-1:0] GAP_MAX    = 16'hffff;
  localparam logic [TIME_W-1:0]  CAP_NARROW = 32'd65535;
  localparam logic [TIME_W-1:0]  CAP_WIDE   = 32'd2147483647;

  typedef enum logic [OP_W-1:0] {
    OP_PACKET = 2'd0,
    OP_TICK   = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [CFG_W-1:0] {
    CFG_LANE_ID_0 = 3'd0,
    CFG_LANE_ID_1 = 3'd1,
    CFG_LANE_ID_2 = 3'd2,
    CFG_LANE_ID_3 = 3'd3,
    CFG_TYPE_A    = 3'd4,
    CFG_TYPE_B    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic               started;
    logic [COUNT_W-1:0] last_count;
    logic [COUNT_W-1:0] car_sum;
    logic [COUNT_W-1:0] gap_ticks;
    logic [TIME_W-1:0]  time_sum;
  } lane_rec_t;

  localparam int REC_W = $bits(lane_rec_t);

  typedef struct packed {
    logic               start;
    logic [TIME_W-1:0]  dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic             valid;
    logic [GAP_W-1:0] gap;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/lha_ram.sv
`default_nettype none
module lha_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 4,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [ADDR_W-1:0]       waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [ADDR_W-1:0]       raddr,
  output      logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/lha_div.sv
`default_nettype none
`include "assert_macros.svh"
module lha_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lha_pkg::div_req_t req,
  output      lha_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(lha_pkg::TIME_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [lha_pkg::COUNT_W-1:0] rem_r, rem_nxt;
  logic [lha_pkg::COUNT_W-1:0] dvs_r, dvs_nxt;
  logic [lha_pkg::TIME_W-1:0]  quo_r, quo_nxt;
  logic [lha_pkg::COUNT_W:0]   trial;
  logic                        fits;

  // One quotient bit per cycle, remainder stays below the divisor.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[lha_pkg::TIME_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? lha_pkg::COUNT_W'(trial - {1'b0, dvs_r})
                     : trial[lha_pkg::COUNT_W-1:0];
      quo_nxt = {quo_r[lha_pkg::TIME_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(lha_pkg::TIME_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

  `ASSERT_NEVER(a_div_restart, req.start && busy_r, "divide started while busy")
  `ASSERT_CLK(a_div_done, $fell(busy_r) |-> done_r, "divide ended without done")

endmodule
`default_nettype wire

FILE: sv/lha_seq.sv
`default_nettype none
`include "assert_macros.svh"
module lha_seq #(
  parameter int LANES = lha_pkg::LANES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output      logic                                  in_ready,
  input  wire logic [lha_pkg::OP_W-1:0]              in_opcode,
  input  wire logic [lha_pkg::TYPE_W-1:0]            in_packet_type,
  input  wire logic [lha_pkg::ID_W-1:0]              in_device_addr,
  input  wire logic [lha_pkg::COUNT_W-1:0]           in_car_count,
  input  wire logic                                  in_wide_result,
  input  wire logic [LANES-1:0][lha_pkg::ID_W-1:0]   lane_id,
  input  wire logic [lha_pkg::TYPE_W-1:0]            type_a,
  input  wire logic [lha_pkg::TYPE_W-1:0]            type_b,
  output      lha_pkg::div_req_t                     div_req,
  input  wire lha_pkg::div_rsp_t                     div_rsp,
  output      lha_pkg::res_t                         res,
  input  wire logic                                  res_ready
);

  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [lha_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [lha_pkg::ID_W-1:0]      addr_r, addr_nxt;
  logic [lha_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic                          wide_r, wide_nxt;
  logic [LANE_W-1:0]             lane_r, lane_nxt;
  logic [LANES-1:0]              valid_r, valid_nxt;
  logic [lha_pkg::COUNT_W-1:0]   csum_r, csum_nxt;
  logic [lha_pkg::TIME_W-1:0]    tsum_r, tsum_nxt;
  logic [lha_pkg::GAP_W-1:0]     gap_r, gap_nxt;

  logic [lha_pkg::REC_W-1:0]     rdata;
  lha_pkg::lane_rec_t            rec, rec_nxt;
  logic                          hit, wr, accept, type_hit, last_lane;
  logic [lha_pkg::COUNT_W-1:0]   added;
  logic [lha_pkg::TIME_W-1:0]    cap, qsat;

  lha_ram #(
    .WIDTH (lha_pkg::REC_W),
    .DEPTH (LANES)
  ) u_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (lane_r),
    .wdata (rec_nxt),
    .raddr (lane_r),
    .rdata (rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign type_hit  = (in_packet_type == type_a) || (in_packet_type == type_b);
  assign last_lane = (lane_r == LANE_W'(LANES - 1));
  assign cap       = wide_r ? lha_pkg::CAP_WIDE : lha_pkg::CAP_NARROW;
  assign qsat      = (div_rsp.quot >= cap) ? cap : div_rsp.quot;

  // Lane record update; a never-written entry reads as its reset value.
  always_comb begin
    rec     = valid_r[lane_r] ? lha_pkg::lane_rec_t'(rdata) : '0;
    hit     = (lane_id[lane_r] == addr_r);
    rec_nxt = rec;
    wr      = 1'b0;
    added   = '0;
    if (state_r == S_WR) begin
      case (op_r)
        lha_pkg::OP_PACKET: begin
          if (hit) begin
            wr = 1'b1;
            if (!rec.started) begin
              rec_nxt.last_count = count_r;
              rec_nxt.car_sum    = rec.car_sum + 1'b1;
              rec_nxt.started    = 1'b1;
            end else begin
              added              = count_r - rec.last_count;
              rec_nxt.car_sum    = rec.car_sum + added;
              rec_nxt.last_count = count_r;
              if (rec.gap_ticks != '0 && added != '0) begin
                rec_nxt.time_sum = rec.time_sum + {16'd0, rec.gap_ticks};
              end
            end
            rec_nxt.gap_ticks = '0;
          end
        end
        lha_pkg::OP_TICK: begin
          if (rec.started && rec.gap_ticks != lha_pkg::GAP_MAX) begin
            wr                = 1'b1;
            rec_nxt.gap_ticks = rec.gap_ticks + 1'b1;
          end
        end
        lha_pkg::OP_READ: begin
          if (hit) begin
            wr               = 1'b1;
            rec_nxt.car_sum  = '0;
            rec_nxt.time_sum = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    count_nxt = count_r;
    wide_nxt  = wide_r;
    lane_nxt  = lane_r;
    valid_nxt = valid_r;
    csum_nxt  = csum_r;
    tsum_nxt  = tsum_r;
    gap_nxt   = gap_r;
    div_req   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_opcode;
          addr_nxt  = in_device_addr;
          count_nxt = in_car_count;
          wide_nxt  = in_wide_result;
          lane_nxt  = '0;
          csum_nxt  = '0;
          tsum_nxt  = '0;
          // Drop unused opcodes and foreign packet types at once.
          if ((in_opcode == lha_pkg::OP_PACKET && type_hit) ||
              in_opcode == lha_pkg::OP_TICK || in_opcode == lha_pkg::OP_READ) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (wr) begin
          valid_nxt[lane_r] = 1'b1;
        end
        // Highest matching lane wins the capture.
        if (op_r == lha_pkg::OP_READ && hit) begin
          csum_nxt = rec.car_sum;
          tsum_nxt = rec.time_sum;
        end
        if (!last_lane) begin
          lane_nxt  = lane_r + 1'b1;
          state_nxt = S_RD;
        end else if (op_r != lha_pkg::OP_READ) begin
          state_nxt = S_IDLE;
        end else if (csum_nxt == '0) begin
          gap_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = tsum_nxt;
          div_req.divisor  = csum_nxt;
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          gap_nxt   = qsat[lha_pkg::GAP_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      lane_r  <= '0;
      op_r    <= lha_pkg::OP_TICK;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      lane_r  <= lane_nxt;
      op_r    <= op_nxt;
    end
    addr_r  <= addr_nxt;
    count_r <= count_nxt;
    wide_r  <= wide_nxt;
    csum_r  <= csum_nxt;
    tsum_r  <= tsum_nxt;
    gap_r   <= gap_nxt;
  end

  assign res.valid = (state_r == S_OUT);
  assign res.gap   = gap_r;

  `ASSERT_CLK(a_rd_before_wr, (state_r == S_WR) |-> ($past(state_r) == S_RD),
              "record modified without a read")
  `ASSERT_CLK(a_div_from_read, div_req.start |-> (op_r == lha_pkg::OP_READ),
              "divide started for a non-read request")

endmodule
`default_nettype wire

FILE: sv/lane_headway_average.sv
// Flow: a packet or tick request reads then writes each lane record in turn through the
// synchronous-read RAM. A read request with a nonzero car sum then runs a restoring divide
// and hands the saturated quotient to the output register.
// Throughput: one request at a time; a new request is accepted only in the idle state.
// Reset: synchronous active-low rst_n clears configuration, lane valid bits and control.
`default_nettype none
module lane_headway_average #(
  parameter int LANES = lha_pkg::LANES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [lha_pkg::OP_W-1:0]          in_opcode,
  input  wire logic [lha_pkg::TYPE_W-1:0]        in_packet_type,
  input  wire logic [lha_pkg::ID_W-1:0]          in_device_addr,
  input  wire logic [lha_pkg::COUNT_W-1:0]       in_car_count,
  input  wire logic                              in_wide_result,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [lha_pkg::GAP_W-1:0]         out_average_gap,
  input  wire logic                              cfg_we,
  input  wire logic [lha_pkg::CFG_W-1:0]         cfg_index,
  input  wire logic [lha_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [LANES-1:0][lha_pkg::ID_W-1:0] lane_id_r;
  logic [lha_pkg::TYPE_W-1:0]          type_a_r, type_b_r;
  logic                                out_valid_r, out_valid_nxt;
  logic [lha_pkg::GAP_W-1:0]           out_gap_r, out_gap_nxt;
  logic                                res_ready;
  lha_pkg::div_req_t                   div_req;
  lha_pkg::div_rsp_t                   div_rsp;
  lha_pkg::res_t                       res;

  // Lane slots beyond the id registers keep id zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_id_r <= '0;
    end else if (cfg_we) begin
      for (int k = 0; k < LANES; k++) begin
        if (k < lha_pkg::NUM_ID_REGS && cfg_index == lha_pkg::CFG_W'(k)) begin
          lane_id_r[k] <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_a_r <= '0;
      type_b_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == lha_pkg::CFG_TYPE_A) begin
        type_a_r <= cfg_wdata[lha_pkg::TYPE_W-1:0];
      end
      if (cfg_index == lha_pkg::CFG_TYPE_B) begin
        type_b_r <= cfg_wdata[lha_pkg::TYPE_W-1:0];
      end
    end
  end

  lha_seq #(
    .LANES (LANES)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_packet_type (in_packet_type),
    .in_device_addr (in_device_addr),
    .in_car_count   (in_car_count),
    .in_wide_result (in_wide_result),
    .lane_id        (lane_id_r),
    .type_a         (type_a_r),
    .type_b         (type_b_r),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .res            (res),
    .res_ready      (res_ready)
  );

  lha_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Output register: hold the result until taken, refill on the same cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_gap_nxt   = out_gap_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_gap_nxt   = res.gap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_gap_r <= out_gap_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_average_gap = out_gap_r;

endmodule
`default_nettype wire
